### sv/radio_frame_checker_macros.svh
// Assertion macros for the radio frame checker.
`ifndef RADIO_FRAME_CHECKER_MACROS_SVH
`define RADIO_FRAME_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define RFC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("radio_frame_checker: assertion failed");

// Next-cycle implication, checked out of reset
`define RFC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("radio_frame_checker: assertion failed");

`else

`define RFC_ASSERT_IMP(label, ante, cons)
`define RFC_ASSERT_NXT(label, ante, cons)

`endif

`endif

### sv/rfc_pkg.sv
// Shared types, codes and the CRC byte update for the radio frame checker.
package rfc_pkg;

	localparam int unsigned HDR_BYTES       = 8;
	localparam int unsigned MIN_FRAME_BYTES = 10;
	localparam logic [15:0] CRC_POLY        = 16'h1021;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;

	// Verdict codes
	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_CRC      = 3'd1,
		ERR_VERSION  = 3'd2,
		ERR_TYPE     = 3'd3,
		ERR_RECEIVER = 3'd4
	} err_kind_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PROTO_VER   = 3'd0,
		REG_FIRST_TYPE  = 3'd1,
		REG_LAST_TYPE   = 3'd2,
		REG_WANTED_TYPE = 3'd3,
		REG_OWN_NODE_ID = 3'd4,
		REG_WILDCARD_ID = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [7:0]  proto_ver;
		logic [7:0]  first_type;
		logic [7:0]  last_type;
		logic [7:0]  wanted_type;
		logic [15:0] own_node_id;
		logic [15:0] wildcard_id;
	} cfg_t;

	// Everything the verdict needs from a finished frame
	typedef struct packed {
		logic        len_ok;
		logic [15:0] crc;
		logic [15:0] given;
		logic [7:0]  version;
		logic [7:0]  frame_type;
		logic [15:0] sender;
		logic [15:0] receiver;
		logic [15:0] sequence_nr;
	} frame_snap_t;

	// CRC-16/CCITT-FALSE over one byte, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### sv/radio_frame_checker.sv
// Top level of the radio frame checker: configuration registers and the two stages.
//
// Takes one frame byte per cycle while in_ready is high, with no gaps needed
// between frames. The CRC over each byte is a single unrolled byte-wide update
// between the frame state registers, so the sustained rate is one byte per clock
// unless the output stalls. A result passes through the frame-end snapshot register
// and then the verdict register. Input stays ready while a result waits, until a
// second finished frame is queued behind it in the snapshot register.
`include "radio_frame_checker_macros.svh"

module radio_frame_checker import rfc_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [2:0]  error_kind,
	output logic [7:0]  version,
	output logic [7:0]  message_type,
	output logic [15:0] source_id,
	output logic [15:0] destination_id,
	output logic [15:0] sequence_res,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t        cfg_q;
	logic        snap_valid;
	logic        snap_ready;
	frame_snap_t snap;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.proto_ver   <= 8'd1;
			cfg_q.first_type  <= 8'd1;
			cfg_q.last_type   <= 8'd5;
			cfg_q.wanted_type <= 8'd0;
			cfg_q.own_node_id <= 16'h0000;
			cfg_q.wildcard_id <= 16'hFFFF;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PROTO_VER:   cfg_q.proto_ver <= cfg_data[7:0];
				REG_FIRST_TYPE:  cfg_q.first_type <= cfg_data[7:0];
				REG_LAST_TYPE:   cfg_q.last_type <= cfg_data[7:0];
				REG_WANTED_TYPE: cfg_q.wanted_type <= cfg_data[7:0];
				REG_OWN_NODE_ID: cfg_q.own_node_id <= cfg_data;
				REG_WILDCARD_ID: cfg_q.wildcard_id <= cfg_data;
				default: ;
			endcase
		end
	end

	rfc_frame #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	rfc_verdict u_verdict (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.snap_valid     (snap_valid),
		.snap_ready     (snap_ready),
		.snap           (snap),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.error_kind     (error_kind),
		.version        (version),
		.message_type   (message_type),
		.source_id      (source_id),
		.destination_id (destination_id),
		.sequence_res   (sequence_res)
	);

	// An empty result register never blocks input
	`RFC_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

	// Accept flag and error code agree
	`RFC_ASSERT_IMP(a_accept_code, out_valid, accepted == (error_kind == ERR_NONE))

	// Rejected frames carry a zeroed header
	`RFC_ASSERT_IMP(a_reject_zero, out_valid && !accepted,
		version == 8'd0 && message_type == 8'd0 && source_id == 16'd0 &&
		destination_id == 16'd0 && sequence_res == 16'd0)

	// A frame end taken with the output free shows up in the snapshot register, then in the result register
	`RFC_ASSERT_NXT(a_latency, in_valid && in_ready && frame_end && !out_valid && !snap_valid,
		snap_valid ##1 out_valid)

endmodule

### sv/rfc_frame.sv
// Per-frame byte tracking: header capture, running CRC, trailer delay, snapshot at frame end.
module rfc_frame import rfc_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	output logic        snap_valid,
	input  logic        snap_ready,
	output frame_snap_t snap
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	logic             accept;
	logic [15:0]      crc_q, crc_next;
	logic [15:0]      delay_q, delay_next;
	logic [CNT_W-1:0] count_q, count_next;
	logic [7:0]       version_q, version_next;
	logic [7:0]       type_q, type_next;
	logic [15:0]      sender_q, sender_next;
	logic [15:0]      receiver_q, receiver_next;
	logic [15:0]      seq_q, seq_next;
	logic             valid_s1;
	frame_snap_t      snap_s1;

	// Snapshot slot frees when the verdict stage takes it
	assign in_ready = !valid_s1 || snap_ready;
	assign accept   = in_valid && in_ready;

	// Next frame state for the byte at hand
	always_comb begin
		version_next  = version_q;
		type_next     = type_q;
		sender_next   = sender_q;
		receiver_next = receiver_q;
		seq_next      = seq_q;
		if (count_q < CNT_W'(HDR_BYTES)) begin
			case (count_q[2:0])
				3'd0: version_next = data_byte;
				3'd1: type_next = data_byte;
				3'd2: sender_next = {sender_q[15:8], data_byte};
				3'd3: sender_next = {data_byte, sender_q[7:0]};
				3'd4: receiver_next = {receiver_q[15:8], data_byte};
				3'd5: receiver_next = {data_byte, receiver_q[7:0]};
				3'd6: seq_next = {seq_q[15:8], data_byte};
				3'd7: seq_next = {data_byte, seq_q[7:0]};
				default: ;
			endcase
		end
		// CRC trails the input by two bytes
		crc_next   = (count_q >= CNT_W'(2)) ? crc16_byte(crc_q, delay_q[15:8]) : crc_q;
		delay_next = {delay_q[7:0], data_byte};
		count_next = (count_q < CNT_W'(MAX_FRAME_BYTES)) ? count_q + CNT_W'(1) : count_q;
	end

	// Frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			delay_q    <= '0;
			count_q    <= '0;
			version_q  <= '0;
			type_q     <= '0;
			sender_q   <= '0;
			receiver_q <= '0;
			seq_q      <= '0;
		end else if (accept) begin
			if (frame_end) begin
				crc_q      <= CRC_INIT;
				delay_q    <= '0;
				count_q    <= '0;
				version_q  <= '0;
				type_q     <= '0;
				sender_q   <= '0;
				receiver_q <= '0;
				seq_q      <= '0;
			end else begin
				crc_q      <= crc_next;
				delay_q    <= delay_next;
				count_q    <= count_next;
				version_q  <= version_next;
				type_q     <= type_next;
				sender_q   <= sender_next;
				receiver_q <= receiver_next;
				seq_q      <= seq_next;
			end
		end
	end

	// Snapshot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && frame_end) begin
			valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Snapshot payload; trailer is little endian
	always_ff @(posedge clk) begin
		if (accept && frame_end) begin
			snap_s1.len_ok      <= (count_next >= CNT_W'(MIN_FRAME_BYTES));
			snap_s1.crc         <= crc_next;
			snap_s1.given       <= {delay_next[7:0], delay_next[15:8]};
			snap_s1.version     <= version_next;
			snap_s1.frame_type  <= type_next;
			snap_s1.sender      <= sender_next;
			snap_s1.receiver    <= receiver_next;
			snap_s1.sequence_nr <= seq_next;
		end
	end

	assign snap_valid = valid_s1;
	assign snap       = snap_s1;

endmodule

### sv/rfc_verdict.sv
// Frame checks in priority order and the result register.
module rfc_verdict import rfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        snap_valid,
	output logic        snap_ready,
	input  frame_snap_t snap,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [2:0]  error_kind,
	output logic [7:0]  version,
	output logic [7:0]  message_type,
	output logic [15:0] source_id,
	output logic [15:0] destination_id,
	output logic [15:0] sequence_res
);

	err_kind_t   err;
	logic        out_valid_q;
	err_kind_t   err_q;
	logic [7:0]  version_q;
	logic [7:0]  type_q;
	logic [15:0] source_q;
	logic [15:0] dest_q;
	logic [15:0] seq_q;

	assign snap_ready = !out_valid_q || out_ready;

	// First failing check wins
	always_comb begin
		err = ERR_NONE;
		if (!snap.len_ok || snap.given != snap.crc) begin
			err = ERR_CRC;
		end else if (snap.version != cfg.proto_ver) begin
			err = ERR_VERSION;
		end else if (snap.frame_type < cfg.first_type || snap.frame_type > cfg.last_type) begin
			err = ERR_TYPE;
		end else if (cfg.wanted_type != 8'd0 && snap.frame_type != cfg.wanted_type) begin
			err = ERR_TYPE;
		end else if (cfg.own_node_id != cfg.wildcard_id) begin
			// beacons go to receiver 0, everything else to this node
			if (snap.frame_type == cfg.first_type) begin
				if (snap.receiver != 16'd0) err = ERR_RECEIVER;
			end else if (snap.receiver != cfg.own_node_id) begin
				err = ERR_RECEIVER;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_ready) begin
			out_valid_q <= snap_valid;
		end
	end

	// Result payload; header zeroed on reject
	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			err_q <= err;
			if (err == ERR_NONE) begin
				version_q <= snap.version;
				type_q    <= snap.frame_type;
				source_q  <= snap.sender;
				dest_q    <= snap.receiver;
				seq_q     <= snap.sequence_nr;
			end else begin
				version_q <= '0;
				type_q    <= '0;
				source_q  <= '0;
				dest_q    <= '0;
				seq_q     <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = (err_q == ERR_NONE);
	assign error_kind     = err_q;
	assign version        = version_q;
	assign message_type   = type_q;
	assign source_id      = source_q;
	assign destination_id = dest_q;
	assign sequence_res   = seq_q;

endmodule
